FILE: hdl/itpd_pkg.sv
// Shared types and constants of the input trigger priority dispatcher.
package itpd_pkg;

   localparam int MAX_INPUTS    = 16;
   localparam int LEVELS_W      = 16;
   localparam int MODE_W        = 3;
   localparam int PRIO_W        = 2;
   localparam int EVENT_INPUT_W = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 48;
   localparam int MODES_W       = MODE_W * MAX_INPUTS;
   localparam int PRIOS_W       = PRIO_W * MAX_INPUTS;

   // trigger modes
   localparam logic [MODE_W-1:0] TRIG_RISE   = 3'd0;
   localparam logic [MODE_W-1:0] TRIG_FALL   = 3'd1;
   localparam logic [MODE_W-1:0] TRIG_CHANGE = 3'd2;
   localparam logic [MODE_W-1:0] TRIG_HIGH   = 3'd3;
   localparam logic [MODE_W-1:0] TRIG_LOW    = 3'd4;

   // priorities
   localparam logic [PRIO_W-1:0] PRIO_NONE   = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_MEDIUM = 2'd2;
   localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_ENABLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MODES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITIES    = 2'd3;

   // reset values: every mode any change, every priority medium
   localparam logic [MODES_W-1:0] MODES_RESET = 48'h4924_9249_2492;
   localparam logic [PRIOS_W-1:0] PRIOS_RESET = 32'hAAAA_AAAA;

   typedef struct packed {
      logic [EVENT_INPUT_W-1:0] event_input;
      logic                     event_level;
      logic [PRIO_W-1:0]        event_priority;
      logic                     last;
   } event_type;

endpackage

FILE: hdl/itpd_req_if.sv
// Sample channel: valid/ready handshake carrying one level sample.
interface itpd_req_if;
   import itpd_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEVELS_W-1:0] levels;

   modport source (output valid, output levels, input ready);
   modport sink   (input valid, input levels, output ready);
endinterface

FILE: hdl/itpd_rsp_if.sv
// Event channel: valid/ready handshake carrying one dispatched event.
interface itpd_rsp_if;
   import itpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [EVENT_INPUT_W-1:0] event_input;
   logic                     event_level;
   logic [PRIO_W-1:0]        event_priority;
   logic                     last;

   modport source (output valid, output event_input, output event_level,
                   output event_priority, output last, input ready);
   modport sink   (input valid, input event_input, input event_level,
                   input event_priority, input last, output ready);
endinterface

FILE: hdl/input_trigger_priority_dispatch_top.sv
// Top level of the input trigger priority dispatcher.
//
// Usage:
//  req_ch carries one sample of input levels per item (valid/ready).
//  rsp_ch carries one event per item: input index, its level, its priority
//  and a last mark on the final event of a sample.
//  csr_* is a plain write port: csr_we, csr_index, csr_wdata. Write only
//  while no sample is still dispatching.
// Path: a sample's events pass through the pending buffer, which loads at the
//  accept edge, then the output register, before they are on rsp_ch.
// Throughput: one event per cycle while rsp_ch is not stalled, set by the single
//  merge stage that picks one event from the pending buffer each cycle. A sample
//  that causes k events (up to NUM_INPUTS) holds the pending buffer until they
//  have left; the next sample is taken in the cycle its last event leaves. Samples
//  that cause no event, or arrive while the block is disabled, never hold it.
// Reset: synchronous, active high. Registers return to their reset values,
//  previous levels clear, pending events and the output register drop.
// Stall: while rsp_ch.ready is low the output register holds its event, the
//  pending buffer holds once that register is full, and req_ch.ready stays
//  low once a sample with events is waiting there.
module input_trigger_priority_dispatch_top #(
   parameter int NUM_INPUTS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   itpd_req_if.sink                               req_ch,
   itpd_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [itpd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [itpd_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import itpd_pkg::*;

   // configuration registers
   logic                block_enable_ff;
   logic [MAX_INPUTS-1:0] input_enables_ff;
   logic [MODES_W-1:0]  trigger_modes_ff;
   logic [PRIOS_W-1:0]  priorities_ff;

   // levels of the last accepted sample while enabled
   logic [NUM_INPUTS-1:0] prev_ff;

   logic [NUM_INPUTS-1:0][PRIO_W-1:0] lane_class;
   logic      accept, load, pend_any, advance;
   event_type head;
   event_type out_event_ff;
   logic      out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_enable_ff  <= 1'b0;
         input_enables_ff <= '0;
         trigger_modes_ff <= MODES_RESET;
         priorities_ff    <= PRIOS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_ENABLE:  block_enable_ff  <= csr_wdata[0];
            CSR_INPUT_ENABLES: input_enables_ff <= csr_wdata[MAX_INPUTS-1:0];
            CSR_TRIGGER_MODES: trigger_modes_ff <= csr_wdata[MODES_W-1:0];
            CSR_PRIORITIES:    priorities_ff    <= csr_wdata[PRIOS_W-1:0];
            default: ;
         endcase
      end
   end

   // one lane per input, all checked in the same cycle
   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
      itpd_lane u_lane (
         .enable      (input_enables_ff[i]),
         .mode        (trigger_modes_ff[MODE_W*i +: MODE_W]),
         .prio        (priorities_ff[PRIO_W*i +: PRIO_W]),
         .prev_level  (prev_ff[i]),
         .now_level   (req_ch.levels[i]),
         .event_class (lane_class[i])
      );
   end

   // merge advances when the output register is free or being drained
   assign advance = pend_any && (!out_valid_ff || rsp_ch.ready);

   // new sample once the buffer is empty or its last event moves out now
   assign req_ch.ready = !pend_any || (advance && head.last);
   assign accept       = req_ch.valid && req_ch.ready;
   assign load         = accept && block_enable_ff;

   itpd_merge #(
      .NUM_INPUTS (NUM_INPUTS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_class  (lane_class),
      .load_levels (req_ch.levels[NUM_INPUTS-1:0]),
      .pop         (advance),
      .pend_any    (pend_any),
      .head        (head)
   );

   // disabled samples leave the stored levels alone
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (load) begin
         prev_ff <= req_ch.levels[NUM_INPUTS-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_event_ff <= head;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.event_input    = out_event_ff.event_input;
   assign rsp_ch.event_level    = out_event_ff.event_level;
   assign rsp_ch.event_priority = out_event_ff.event_priority;
   assign rsp_ch.last           = out_event_ff.last;

   // a shown event always has a real priority
   a_prio_real: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_event_ff.event_priority != PRIO_NONE)
      else $error("event shown with priority none");

   // a sample taken while disabled must not move the stored levels
   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !block_enable_ff) |=> $stable(prev_ff))
      else $error("stored levels changed on a disabled sample");

   // pending events with a free output register show up next cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pend_any && !out_valid_ff) |=> out_valid_ff)
      else $error("pending event not moved to output");

   // no sample is taken while events other than the outgoing one wait
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (accept && pend_any) |-> (advance && head.last))
      else $error("sample accepted over pending events");

endmodule

FILE: hdl/itpd_lane.sv
// One detection lane: trigger check of one input, yields its event class.
module itpd_lane (
   input  logic                          enable,
   input  logic [itpd_pkg::MODE_W-1:0]   mode,
   input  logic [itpd_pkg::PRIO_W-1:0]   prio,
   input  logic                          prev_level,
   input  logic                          now_level,
   output logic [itpd_pkg::PRIO_W-1:0]   event_class
);
   import itpd_pkg::*;

   logic fired;

   always_comb begin
      unique case (mode)
         TRIG_RISE:   fired = !prev_level && now_level;
         TRIG_FALL:   fired = prev_level && !now_level;
         TRIG_CHANGE: fired = prev_level != now_level;
         TRIG_HIGH:   fired = now_level;
         TRIG_LOW:    fired = !now_level;
         default:     fired = 1'b0;
      endcase
   end

   // class none means no event from this lane
   assign event_class = (enable && fired) ? prio : PRIO_NONE;

endmodule

FILE: hdl/itpd_merge.sv
// Merge stage: holds lane classes of one sample, hands out events in order.
module itpd_merge #(
   parameter int NUM_INPUTS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load,
   input  logic [NUM_INPUTS-1:0][itpd_pkg::PRIO_W-1:0] load_class,
   input  logic [NUM_INPUTS-1:0]                       load_levels,
   input  logic                                        pop,
   output logic                                        pend_any,
   output itpd_pkg::event_type                         head
);
   import itpd_pkg::*;

   localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

   logic [NUM_INPUTS-1:0][PRIO_W-1:0] class_ff, class_in;
   logic [NUM_INPUTS-1:0]             level_ff;
   logic [NUM_INPUTS-1:0]             mask_hi, mask_med, mask_low, nonzero;
   logic [NUM_INPUTS-1:0]             sel_mask, sel_onehot, rest;
   logic [PRIO_W-1:0]                 sel_prio;
   logic [IDX_W-1:0]                  sel_idx;

   always_comb begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
         mask_hi[i]  = class_ff[i] == PRIO_HIGH;
         mask_med[i] = class_ff[i] == PRIO_MEDIUM;
         mask_low[i] = class_ff[i] == PRIO_LOW;
         nonzero[i]  = class_ff[i] != PRIO_NONE;
      end
   end

   always_comb begin
      if (|mask_hi) begin
         sel_mask = mask_hi;
         sel_prio = PRIO_HIGH;
      end else if (|mask_med) begin
         sel_mask = mask_med;
         sel_prio = PRIO_MEDIUM;
      end else begin
         sel_mask = mask_low;
         sel_prio = PRIO_LOW;
      end
   end

   // lowest set bit of the winning class
   assign sel_onehot = sel_mask & (~sel_mask + NUM_INPUTS'(1));
   assign rest       = nonzero & ~sel_onehot;
   assign pend_any   = |nonzero;

   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         if (sel_onehot[i]) begin
            sel_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      head.event_input    = EVENT_INPUT_W'(sel_idx);
      head.event_level    = level_ff[sel_idx];
      head.event_priority = sel_prio;
      head.last           = ~|rest;
   end

   always_comb begin
      class_in = class_ff;
      if (load) begin
         class_in = load_class;
      end else if (pop) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            if (sel_onehot[i]) begin
               class_in[i] = PRIO_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= '0;
      end else begin
         class_ff <= class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= load_levels;
      end
   end

endmodule

FILE: sim/tb_input_trigger_priority_dispatch_top.sv
// Testbench for the input trigger priority dispatcher: directed table, then random phases.
module tb_input_trigger_priority_dispatch_top;
   timeunit 1ns;
   timeprecision 1ps;

   import itpd_pkg::*;

   localparam int NUM_INPUTS   = 16;
   localparam int MAX_GAP      = 17;      // longest idle drawn per item, either side
   localparam int SETTLE_WAIT  = 4;       // first event shows up through the pending buffer and output register
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off for the back-pressure phase
   localparam int CYCLE_LIMIT  = 400000;  // bound for the run guard below
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_ITEMS  = 30;
   localparam int PRESS_PHASE  = 5;
   localparam int OFF_PHASE    = 3;
   localparam int FULL_PHASE   = 2;
   localparam int NUM_ROWS     = 39;

   localparam logic [LEVELS_W-1:0] LEVEL_MASK = LEVELS_W'((1 << NUM_INPUTS) - 1);

   // trigger codes above TRIG_LOW are reserved and never fire
   localparam logic [MODE_W-1:0] TRIG_RSVD5 = 3'd5;
   localparam logic [MODE_W-1:0] TRIG_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] TRIG_RSVD7 = 3'd7;

   // whole-register patterns; slot i of a replicated concat is input i
   localparam logic [MODES_W-1:0] MODES_RISE   = {MAX_INPUTS{TRIG_RISE}};
   localparam logic [MODES_W-1:0] MODES_FALL   = {MAX_INPUTS{TRIG_FALL}};
   localparam logic [MODES_W-1:0] MODES_CHANGE = {MAX_INPUTS{TRIG_CHANGE}};
   localparam logic [MODES_W-1:0] MODES_HIGH   = {MAX_INPUTS{TRIG_HIGH}};
   localparam logic [MODES_W-1:0] MODES_LOW    = {MAX_INPUTS{TRIG_LOW}};
   localparam logic [MODES_W-1:0] MODES_RSVD   =
      {{5{TRIG_RSVD7, TRIG_RSVD6, TRIG_RSVD5}}, TRIG_RSVD5};
   // input i gets code i mod 8: every code, reserved ones included
   localparam logic [MODES_W-1:0] MODES_MIXED  =
      {2{TRIG_RSVD7, TRIG_RSVD6, TRIG_RSVD5, TRIG_LOW,
         TRIG_HIGH, TRIG_CHANGE, TRIG_FALL, TRIG_RISE}};
   localparam logic [PRIOS_W-1:0] PRIOS_NONE   = {MAX_INPUTS{PRIO_NONE}};
   localparam logic [PRIOS_W-1:0] PRIOS_LOW    = {MAX_INPUTS{PRIO_LOW}};
   localparam logic [PRIOS_W-1:0] PRIOS_HIGH   = {MAX_INPUTS{PRIO_HIGH}};
   // input 0 high, 1 medium, 2 low, 3 none, repeated
   localparam logic [PRIOS_W-1:0] PRIOS_MIXED  =
      {4{PRIO_NONE, PRIO_LOW, PRIO_MEDIUM, PRIO_HIGH}};

   localparam event_type NO_EVT = '0;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // One line of the directed table. A sample row with known set carries its
   // expected outcome typed in (zero or one event); all other sample rows go
   // through the predictor.
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic [LEVELS_W-1:0]   levels;
      bit                    known;
      int                    known_count;
      event_type             known_evt;
   } stim_row_type;

   stim_row_type dir_rows [NUM_ROWS] = '{
      // right after reset the block is off: the sample is dropped
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFF, 1'b1, 0, NO_EVT},
      // enable, with junk above bit 0 that must be dropped
      '{ROW_WRITE, CSR_BLOCK_ENABLE, 48'hFFFF_FFFF_FFFF, 16'h0, 1'b0, 0, NO_EVT},
      // enabled but no input enabled: nothing fires, previous levels -> FFFF
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFF, 1'b1, 0, NO_EVT},
      // only input 0 enabled; upper junk bits dropped
      '{ROW_WRITE, CSR_INPUT_ENABLES, 48'h0000_FFFF_0001, 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0000, 1'b1, 1,
        '{4'd0, 1'b0, PRIO_MEDIUM, 1'b1}},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0001, 1'b1, 1,
        '{4'd0, 1'b1, PRIO_MEDIUM, 1'b1}},
      '{ROW_WRITE, CSR_INPUT_ENABLES, 48'h0000_0000_FFFF, 16'h0, 1'b0, 0, NO_EVT},
      // every input toggles: a full run of sixteen events
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFE, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFE, 1'b1, 0, NO_EVT},
      '{ROW_WRITE, CSR_PRIORITIES, 48'(PRIOS_MIXED), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0001, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h8000, 1'b0, 0, NO_EVT},
      // block off: sample ignored and previous levels kept at 8000
      '{ROW_WRITE, CSR_BLOCK_ENABLE, 48'h0, 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h7FFF, 1'b1, 0, NO_EVT},
      '{ROW_WRITE, CSR_BLOCK_ENABLE, 48'h1, 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h8000, 1'b1, 0, NO_EVT},
      // all rising (register at zero)
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_RISE), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0000, 1'b1, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFF, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_FALL), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h5A5A, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_HIGH), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_PRIORITIES, 48'(PRIOS_HIGH), 16'h0, 1'b0, 0, NO_EVT},
      // level modes fire again on a repeated sample
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hA5A5, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hA5A5, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_LOW), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_PRIORITIES, 48'(PRIOS_LOW), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0F0F, 1'b0, 0, NO_EVT},
      // reserved codes only: nothing fires
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'hFFFF_FFFF_FFFF, 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hF0F0, 1'b1, 0, NO_EVT},
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_RSVD), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0F0F, 1'b1, 0, NO_EVT},
      // every code present, but priority none everywhere: no events
      '{ROW_WRITE, CSR_TRIGGER_MODES, 48'(MODES_MIXED), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_WRITE, CSR_PRIORITIES, 48'(PRIOS_NONE), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hF0F0, 1'b1, 0, NO_EVT},
      '{ROW_WRITE, CSR_PRIORITIES, 48'(PRIOS_MIXED), 16'h0, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0F0F, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'hFFFF, 1'b0, 0, NO_EVT},
      '{ROW_SAMPLE, CSR_BLOCK_ENABLE, 48'h0, 16'h0000, 1'b0, 0, NO_EVT}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   itpd_req_if req_ch ();
   itpd_rsp_if rsp_ch ();

   input_trigger_priority_dispatch_top #(
      .NUM_INPUTS (NUM_INPUTS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and the kept levels
   logic                  cfg_enable;
   logic [LEVELS_W-1:0]   cfg_input_en;
   logic [MODES_W-1:0]    cfg_modes;
   logic [PRIOS_W-1:0]    cfg_prios;
   logic [LEVELS_W-1:0]   prev_levels;

   // Events still owed by the block, oldest first
   event_type             pending_events[$];

   int                    error_count = 0;
   int                    cycle_count = 0;
   bit                    req_idle_on = 1'b0;
   bit                    rsp_idle_on = 1'b0;
   bit                    rsp_hold    = 1'b0;
   int                    rsp_gap     = 0;
   event_type             got_evt;
   event_type             want_evt;
   event                  hold_go;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[input_trigger_priority_dispatch_top] ERROR");
         $finish;
      end
   end

   // Works out the events a sample causes and appends them to the queue.
   // Order: high, then medium, then low priority; ascending index within one.
   function automatic void dispatch_events(input logic [LEVELS_W-1:0] levels,
                                           ref event_type events[$]);
      logic [MAX_INPUTS-1:0] fired;
      logic [LEVELS_W-1:0]   now_lv;
      logic [MODE_W-1:0]     mode;
      logic                  was, is_now, hit;
      event_type             ev;
      int                    first;
      first = events.size();
      if (!cfg_enable)
         return;
      now_lv = levels & LEVEL_MASK;
      fired  = '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         mode   = cfg_modes[i*MODE_W +: MODE_W];
         was    = prev_levels[i];
         is_now = now_lv[i];
         case (mode)
            TRIG_RISE:   hit = !was && is_now;
            TRIG_FALL:   hit = was && !is_now;
            TRIG_CHANGE: hit = was != is_now;
            TRIG_HIGH:   hit = is_now;
            TRIG_LOW:    hit = !is_now;
            default:     hit = 1'b0;
         endcase
         fired[i] = cfg_input_en[i] && hit;
      end
      prev_levels = now_lv;
      for (int p = int'(PRIO_HIGH); p >= int'(PRIO_LOW); p--) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            if (fired[i] && cfg_prios[i*PRIO_W +: PRIO_W] == PRIO_W'(p)) begin
               ev.event_input    = EVENT_INPUT_W'(i);
               ev.event_level    = now_lv[i];
               ev.event_priority = PRIO_W'(p);
               ev.last           = 1'b0;
               events.push_back(ev);
            end
         end
      end
      if (events.size() > first)
         events[events.size()-1].last = 1'b1;
   endfunction

   // Register write: one cycle of csr_we, predictor copy follows at once;
   // then csr_we stays low before returning, so that writes in a row never overlap
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_BLOCK_ENABLE:  cfg_enable   = data[0];
         CSR_INPUT_ENABLES: cfg_input_en = data[LEVELS_W-1:0];
         CSR_TRIGGER_MODES: cfg_modes    = data[MODES_W-1:0];
         CSR_PRIORITIES:    cfg_prios    = data[PRIOS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offers one sample, after a random idle gap if req_idle_on, and returns at its accept edge.
   // valid stays high into the next item when the next gap is zero.
   task automatic offer_sample(input logic [LEVELS_W-1:0] lv);
      int gap;
      gap = req_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.levels <= lv;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Sender pause: wait out every owed event, then a further SETTLE_WAIT wait in case the
   // block is still chewing on a sample that gives no event.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Long receiver hold-off, counted here so the sender can keep offering
   initial begin
      forever begin
         @(hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Event side: check each accepted event against the oldest one owed, then
   // draw how long ready stays low before the next item.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_evt.event_input    = rsp_ch.event_input;
            got_evt.event_level    = rsp_ch.event_level;
            got_evt.event_priority = rsp_ch.event_priority;
            got_evt.last           = rsp_ch.last;
            if (pending_events.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected event: input %0d level %0d prio %0d last %0d",
                           got_evt.event_input, got_evt.event_level,
                           got_evt.event_priority, got_evt.last);
            end else begin
               want_evt = pending_events.pop_front();
               if (got_evt.event_input    !== want_evt.event_input ||
                   got_evt.event_level    !== want_evt.event_level ||
                   got_evt.event_priority !== want_evt.event_priority ||
                   got_evt.last           !== want_evt.last) begin
                  error_count++;
                  // fields in order: input, level, prio, last
                  if (error_count <= 10)
                     $display("event mismatch: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want_evt.event_input, want_evt.event_level,
                              want_evt.event_priority, want_evt.last,
                              got_evt.event_input, got_evt.event_level,
                              got_evt.event_priority, got_evt.last);
               end
            end
            rsp_gap = rsp_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
         end
         if (rsp_hold || rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            if (rsp_gap > 0)
               rsp_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed table, then random phases
   initial begin
      event_type           scratch[$];
      logic [LEVELS_W-1:0] lv;
      logic [LEVELS_W-1:0] last_lv;
      logic [MODES_W-1:0]  modes_v;
      logic [63:0]         wide;
      bit                  pressure;
      bit                  full_cfg;
      int                  n_items;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.levels = '0;
      rsp_ch.ready  = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_BLOCK_ENABLE;
      csr_wdata     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      cfg_enable   = 1'b0;
      cfg_input_en = '0;
      cfg_modes    = MODES_RESET;
      cfg_prios    = PRIOS_RESET;
      prev_levels  = '0;
      last_lv      = '0;

      // Directed part. Gaps on the sample side stay on; receiver runs free.
      req_idle_on = 1'b1;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_WRITE) begin
            settle();
            write_reg(dir_rows[r].csr_idx, dir_rows[r].csr_data);
         end else begin
            offer_sample(dir_rows[r].levels);
            last_lv = dir_rows[r].levels;
            if (dir_rows[r].known) begin
               // typed-in outcome; predictor only advances its state
               dispatch_events(dir_rows[r].levels, scratch);
               scratch.delete();
               if (dir_rows[r].known_count != 0)
                  pending_events.push_back(dir_rows[r].known_evt);
            end else begin
               dispatch_events(dir_rows[r].levels, pending_events);
            end
         end
      end

      // Random phases. Each phase starts idle, rewrites every register and
      // picks its own idling: both sides free, either side gapping, or both.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         pressure = (ph == PRESS_PHASE);
         full_cfg = (ph == FULL_PHASE) || pressure;
         req_idle_on = (ph % 2 == 1) && !pressure;
         rsp_idle_on <= ((ph / 2) % 2 == 1) && !pressure;

         // junk in the upper data bits must be dropped by every register
         wide    = {$urandom(), $urandom()};
         wide[0] = (ph != OFF_PHASE);
         write_reg(CSR_BLOCK_ENABLE, wide[CSR_DATA_W-1:0]);
         wide = {$urandom(), $urandom()};
         if (full_cfg)
            wide[LEVELS_W-1:0] = '1;
         write_reg(CSR_INPUT_ENABLES, wide[CSR_DATA_W-1:0]);
         // mostly live trigger codes, a quarter drawn from all eight
         for (int s = 0; s < MAX_INPUTS; s++) begin
            if ($urandom_range(0, 3) == 0)
               modes_v[s*MODE_W +: MODE_W] = MODE_W'($urandom_range(0, int'(TRIG_RSVD7)));
            else
               modes_v[s*MODE_W +: MODE_W] = MODE_W'($urandom_range(0, int'(TRIG_LOW)));
         end
         if (full_cfg)
            modes_v = MODES_CHANGE;
         write_reg(CSR_TRIGGER_MODES, 48'(modes_v));
         wide = {$urandom(), $urandom()};
         if (ph == FULL_PHASE)
            wide[PRIOS_W-1:0] = PRIOS_HIGH;
         write_reg(CSR_PRIORITIES, wide[CSR_DATA_W-1:0]);

         // back-pressure: receiver holds off while samples keep coming
         // back to back, so the block fills and drops req ready
         if (pressure)
            -> hold_go;

         n_items = (ph == OFF_PHASE) ? 10 : PHASE_ITEMS;
         for (int k = 0; k < n_items; k++) begin
            if (!pressure && $urandom_range(0, 19) == 0)
               settle();
            if (pressure) begin
               // near-complement of the last sample: long runs of events
               lv = ~last_lv ^ (16'h1 << $urandom_range(0, LEVELS_W-1));
            end else begin
               case ($urandom_range(0, 9)) inside
                  0:       lv = '0;
                  1:       lv = '1;
                  [2:5]:   lv = last_lv ^ (16'h1 << $urandom_range(0, LEVELS_W-1))
                                        ^ (16'h1 << $urandom_range(0, LEVELS_W-1));
                  default: lv = LEVELS_W'($urandom());
               endcase
            end
            offer_sample(lv);
            dispatch_events(lv, pending_events);
            last_lv = lv;
         end
      end

      // drain, then a short tail to catch any stray extra event
      settle();
      repeat (2 * SETTLE_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("[input_trigger_priority_dispatch_top] OK");
      else
         $display("[input_trigger_priority_dispatch_top] ERROR");
      $finish;
   end

endmodule
